FILE: rtl/core/tnns_pkg.sv
// tree nearest node search: shared types, widths and codes
// used by the channel interfaces, the node memory, the distance unit and the top level
package tnns_pkg;

  localparam int MAX_NODES_DEF = 2048;
  localparam int JOINTS        = 6;
  localparam int ANGLE_W       = 16;
  localparam int NODE_IDX_W    = 11;
  localparam int PARENT_W      = 12;
  localparam int DIST_W        = 35;
  localparam int SQ_W          = 2 * ANGLE_W;
  localparam int PAIR_W        = SQ_W + 1;
  localparam int QUAD_W        = SQ_W + 2;
  localparam int PAIR_N        = (JOINTS + 1) / 2;
  localparam int QUAD_N        = (PAIR_N + 1) / 2;

  localparam logic [PARENT_W-1:0] NO_PARENT = '1;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_APPEND  = 2'd1,
    MODE_NEAREST = 2'd2,
    MODE_READ    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_ROOM    = 2'd1,
    STAT_EMPTY      = 2'd2,
    STAT_NOT_STORED = 2'd3
  } status_t;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef angle_t [JOINTS-1:0] angle_vec_t;

  typedef struct packed {
    angle_vec_t          angle;
    logic [PARENT_W-1:0] parent;
  } node_row_t;

  typedef struct packed {
    status_t               status;
    logic [NODE_IDX_W-1:0] node_index;
    logic [DIST_W-1:0]     dist_sq;
    angle_vec_t            angle;
    logic [PARENT_W-1:0]   parent;
  } result_t;

endpackage

FILE: rtl/core/tnns_ifs.sv
// valid/ready channel interfaces for the request and result items
// depends on tnns_pkg for field widths
interface tnns_in_if;
  import tnns_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [ANGLE_W-1:0]    joint_0;
  logic signed [ANGLE_W-1:0]    joint_1;
  logic signed [ANGLE_W-1:0]    joint_2;
  logic signed [ANGLE_W-1:0]    joint_3;
  logic signed [ANGLE_W-1:0]    joint_4;
  logic signed [ANGLE_W-1:0]    joint_5;
  logic [NODE_IDX_W-1:0]        parent_in;
  logic [NODE_IDX_W-1:0]        read_index;

  modport source (
    output valid, mode, joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
           parent_in, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, joint_0, joint_1, joint_2, joint_3, joint_4, joint_5,
           parent_in, read_index,
    output ready
  );
endinterface

interface tnns_out_if;
  import tnns_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [NODE_IDX_W-1:0]        node_index;
  logic [DIST_W-1:0]            dist_sq;
  logic signed [ANGLE_W-1:0]    out_joint_0;
  logic signed [ANGLE_W-1:0]    out_joint_1;
  logic signed [ANGLE_W-1:0]    out_joint_2;
  logic signed [ANGLE_W-1:0]    out_joint_3;
  logic signed [ANGLE_W-1:0]    out_joint_4;
  logic signed [ANGLE_W-1:0]    out_joint_5;
  logic signed [PARENT_W-1:0]   parent_out;

  modport source (
    output valid, status, node_index, dist_sq, out_joint_0, out_joint_1, out_joint_2,
           out_joint_3, out_joint_4, out_joint_5, parent_out,
    input  ready
  );
  modport sink (
    input  valid, status, node_index, dist_sq, out_joint_0, out_joint_1, out_joint_2,
           out_joint_3, out_joint_4, out_joint_5, parent_out,
    output ready
  );
endinterface

FILE: rtl/core/tree_nearest_node_search_top.sv
// tree nearest node search: node table with append, read and nearest-node scan
// depends on tnns_pkg, tnns_ifs, tnns_node_mem and tnns_dist_unit
//
//   channel  | direction | handshake   | carries
//   in_if    | in        | valid/ready | mode, joint_0..5, parent_in, read_index
//   out_if   | out       | valid/ready | status, node_index, dist_sq, out_joint_0..5, parent_out
//
// start and append go through the put state into the output register; a stored read passes the read state first
// nearest search: the node memory read port gives one row per cycle to the distance
// pipeline, and the running minimum follows it
// a new item is taken only in idle; a result waits in the output register while the
// next item is worked on, and a further result holds until that register frees
// reset clears the node count, the state and the valid flags; the node table has no reset and no clearing pass
module tree_nearest_node_search_top #(
  parameter int MAX_NODES = tnns_pkg::MAX_NODES_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tnns_in_if.sink  in_if,
  tnns_out_if.source out_if
);
  import tnns_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (CNT_W > NODE_IDX_W) ? CNT_W : NODE_IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_PUT  = 4'b1000
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  issue_r;
  logic              rd_vld_r;
  logic [IDX_W-1:0]  rd_tag_r;
  angle_vec_t        tgt_r;
  logic [DIST_W-1:0] best_r;
  logic [IDX_W-1:0]  best_idx_r;
  result_t           res_r;
  result_t           out_r;
  logic              out_vld_r;

  logic              accept;
  mode_t             mode;
  angle_vec_t        in_vec;
  logic              no_room;
  logic              is_empty;
  logic              parent_bad;
  logic              read_bad;
  logic              append_ok;
  logic              put_go;
  logic              scan_issue;
  result_t           res_acc;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  node_row_t         wr_row;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  node_row_t         rd_row;

  logic              dist_vld;
  logic [IDX_W-1:0]  dist_tag;
  logic [DIST_W-1:0] dist_sum;
  logic              take;
  logic              last;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid & in_if.ready;
  assign mode        = mode_t'(in_if.mode);

  assign in_vec[0] = in_if.joint_0;
  assign in_vec[1] = in_if.joint_1;
  assign in_vec[2] = in_if.joint_2;
  assign in_vec[3] = in_if.joint_3;
  assign in_vec[4] = in_if.joint_4;
  assign in_vec[5] = in_if.joint_5;

  assign no_room    = (count_r == CNT_W'(MAX_NODES));
  assign is_empty   = (count_r == '0);
  assign parent_bad = (CMP_W'(in_if.parent_in) >= CMP_W'(count_r));
  assign read_bad   = (CMP_W'(in_if.read_index) >= CMP_W'(count_r));
  assign append_ok  = !no_room && !parent_bad;
  assign put_go     = (state_r == ST_PUT) && (!out_vld_r || out_if.ready);
  assign scan_issue = (state_r == ST_SCAN) && (issue_r < count_r);

  // result fields settled at accept time
  always_comb begin
    res_acc = '0;
    unique case (mode)
      MODE_START: begin
        res_acc.status = STAT_OK;
      end
      MODE_APPEND: begin
        if (no_room) begin
          res_acc.status = STAT_NO_ROOM;
        end else if (parent_bad) begin
          res_acc.status = STAT_NOT_STORED;
        end else begin
          res_acc.node_index = NODE_IDX_W'(count_r);
        end
      end
      MODE_NEAREST: begin
        if (is_empty) begin
          res_acc.status = STAT_EMPTY;
        end
      end
      MODE_READ: begin
        res_acc.node_index = in_if.read_index;
        if (read_bad) begin
          res_acc.status = STAT_NOT_STORED;
        end
      end
      default: res_acc = '0;
    endcase
  end

  assign wr_en         = accept && ((mode == MODE_START) || ((mode == MODE_APPEND) && append_ok));
  assign wr_addr       = (mode == MODE_START) ? '0 : IDX_W'(count_r);
  assign wr_row.angle  = in_vec;
  assign wr_row.parent = (mode == MODE_START) ? NO_PARENT : PARENT_W'(in_if.parent_in);
  assign rd_en         = scan_issue || (accept && (mode == MODE_READ) && !read_bad);
  assign rd_addr       = scan_issue ? IDX_W'(issue_r) : IDX_W'(in_if.read_index);

  tnns_node_mem #(
    .DEPTH  (MAX_NODES),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_row  (wr_row),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_row  (rd_row)
  );

  tnns_dist_unit #(
    .TAG_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (rd_vld_r),
    .in_tag    (rd_tag_r),
    .row       (rd_row.angle),
    .target    (tgt_r),
    .out_valid (dist_vld),
    .out_tag   (dist_tag),
    .out_sum   (dist_sum)
  );

  // strict less keeps the lowest index on ties
  assign take = dist_vld && ((dist_tag == '0) || (dist_sum < best_r));
  assign last = dist_vld && (CNT_W'(dist_tag) == count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= scan_issue;
      if (put_go) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            unique case (mode)
              MODE_START: begin
                count_r <= CNT_W'(1);
                state_r <= ST_PUT;
              end
              MODE_APPEND: begin
                if (append_ok) begin
                  count_r <= count_r + CNT_W'(1);
                end
                state_r <= ST_PUT;
              end
              MODE_NEAREST: state_r <= is_empty ? ST_PUT : ST_SCAN;
              MODE_READ:    state_r <= read_bad ? ST_PUT : ST_READ;
              default:      state_r <= ST_PUT;
            endcase
          end
        end
        ST_READ: state_r <= ST_PUT;
        ST_SCAN: begin
          if (last) begin
            state_r <= ST_PUT;
          end
        end
        ST_PUT: begin
          if (put_go) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_tag_r <= IDX_W'(issue_r);
    if (accept) begin
      issue_r <= '0;
      tgt_r   <= in_vec;
      res_r   <= res_acc;
    end else begin
      if (scan_issue) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      if (state_r == ST_READ) begin
        res_r.angle  <= rd_row.angle;
        res_r.parent <= rd_row.parent;
      end
      if (last) begin
        res_r.node_index <= NODE_IDX_W'(take ? dist_tag : best_idx_r);
        res_r.dist_sq    <= take ? dist_sum : best_r;
      end
    end
    if (take) begin
      best_r     <= dist_sum;
      best_idx_r <= dist_tag;
    end
    if (put_go) begin
      out_r <= res_r;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.status      = out_r.status;
  assign out_if.node_index  = out_r.node_index;
  assign out_if.dist_sq     = out_r.dist_sq;
  assign out_if.out_joint_0 = out_r.angle[0];
  assign out_if.out_joint_1 = out_r.angle[1];
  assign out_if.out_joint_2 = out_r.angle[2];
  assign out_if.out_joint_3 = out_r.angle[3];
  assign out_if.out_joint_4 = out_r.angle[4];
  assign out_if.out_joint_5 = out_r.angle[5];
  assign out_if.parent_out  = out_r.parent;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_NODES))
    else $error("node count above table size");

  a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dist_vld |-> (state_r == ST_SCAN))
    else $error("distance result outside a scan");

  a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode == MODE_APPEND) && append_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not advance node count");

  a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> ($past(state_r) == ST_PUT))
    else $error("result presented without a finished item");

endmodule

FILE: rtl/core/tnns_node_mem.sv
// node table memory: one row per node holding all joint angles and the parent
// one write port, one read port with registered read data; depends on tnns_pkg
module tnns_node_mem #(
  parameter int DEPTH  = tnns_pkg::MAX_NODES_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  tnns_pkg::node_row_t wr_row,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output tnns_pkg::node_row_t rd_row
);
  import tnns_pkg::*;

  node_row_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/tnns_dist_unit.sv
// pipelined squared joint-space distance unit, one node row per cycle
// abs diff, square, two add stages and a final sum; depends on tnns_pkg
module tnns_dist_unit #(
  parameter int TAG_W = $clog2(tnns_pkg::MAX_NODES_DEF)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [TAG_W-1:0]            in_tag,
  input  tnns_pkg::angle_vec_t        row,
  input  tnns_pkg::angle_vec_t        target,
  output logic                        out_valid,
  output logic [TAG_W-1:0]            out_tag,
  output logic [tnns_pkg::DIST_W-1:0] out_sum
);
  import tnns_pkg::*;

  logic [4:0]                         vld_r;
  logic [4:0][TAG_W-1:0]              tag_r;
  logic [JOINTS-1:0][ANGLE_W:0]       diff_c;
  logic [JOINTS-1:0][ANGLE_W-1:0]     abs_r;
  logic [2*PAIR_N-1:0][SQ_W-1:0]      sq_r;
  logic [2*QUAD_N-1:0][PAIR_W-1:0]    pair_r;
  logic [QUAD_N-1:0][QUAD_W-1:0]      quad_r;
  logic [DIST_W-1:0]                  sum_c;
  logic [DIST_W-1:0]                  sum_r;

  always_comb begin
    for (int j = 0; j < JOINTS; j++) begin
      diff_c[j] = {row[j][ANGLE_W-1], row[j]} - {target[j][ANGLE_W-1], target[j]};
    end
  end

  always_comb begin
    sum_c = '0;
    for (int q = 0; q < QUAD_N; q++) begin
      sum_c = sum_c + DIST_W'(quad_r[q]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= {tag_r[3:0], in_tag};
    for (int j = 0; j < JOINTS; j++) begin
      abs_r[j] <= diff_c[j][ANGLE_W] ? ANGLE_W'(~diff_c[j] + 1'b1) : diff_c[j][ANGLE_W-1:0];
    end
    // odd joint counts pad the last pair with zero
    for (int j = 0; j < 2 * PAIR_N; j++) begin
      sq_r[j] <= (j < JOINTS) ? abs_r[j] * abs_r[j] : '0;
    end
    for (int p = 0; p < 2 * QUAD_N; p++) begin
      pair_r[p] <= (p < PAIR_N) ? {1'b0, sq_r[2*p]} + {1'b0, sq_r[2*p+1]} : '0;
    end
    for (int q = 0; q < QUAD_N; q++) begin
      quad_r[q] <= {1'b0, pair_r[2*q]} + {1'b0, pair_r[2*q+1]};
    end
    sum_r <= sum_c;
  end

  assign out_valid = vld_r[4];
  assign out_tag   = tag_r[4];
  assign out_sum   = sum_r;

endmodule
